[design/sce_pkg.sv]
// Shared types and constants for the selected cell enumerator.
// Command and status codes, register indexes, beat layouts and the structs between modules.
// No dependencies; every other design file uses it.
`timescale 1ns / 1ps

package sce_pkg;

  localparam int CMD_W       = 2;
  localparam int DIM_W       = 2;
  localparam int MEMBER_W    = 7;
  localparam int STATUS_W    = 2;
  localparam int SIZE_W      = 8;
  localparam int DIMS_CFG_W  = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int OUT_DIMS    = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_SEL_MEMBER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEL_ALL    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ADVANCE    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ACK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CELL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_RUN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3   = 3'd4;

  localparam logic [DIMS_CFG_W-1:0] DIMS_IN_USE_RST = 3'd4;
  localparam logic [SIZE_W-1:0]     SIZE_RST        = 8'd128;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [DIM_W-1:0]    dim;
    logic [MEMBER_W-1:0] member;
  } in_item_t;

  // Update request for the selection bitmaps.
  typedef struct packed {
    logic                wr;
    logic                all;
    logic [DIM_W-1:0]    dim;
    logic [MEMBER_W-1:0] member;
    logic [SIZE_W-1:0]   count;
  } sel_cmd_t;

  // Scan flags of one dimension.
  typedef struct packed {
    logic any;        // some member selected
    logic multi;      // two or more members selected
    logic nxt_any;    // a selected member above the position
    logic nxt_multi;  // two or more selected members above the position
  } scan_flags_t;

endpackage

[design/sce_sel_map.sv]
// Selection bitmaps, one row of member bits per dimension.
// Applies select member and select all updates. Depends on sce_pkg.
`timescale 1ns / 1ps

module sce_sel_map #(
  parameter int MAX_DIMS    = 4,
  parameter int MAX_MEMBERS = 128
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sce_pkg::sel_cmd_t                     sel_cmd,
  output logic [MAX_DIMS-1:0][MAX_MEMBERS-1:0]  map_o
);

  logic [MAX_DIMS-1:0][MAX_MEMBERS-1:0] map_r;
  logic [MAX_DIMS-1:0][MAX_MEMBERS-1:0] map_nxt;

  always_comb begin
    map_nxt = map_r;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (int'(sel_cmd.dim) == d) begin
        for (int m = 0; m < MAX_MEMBERS; m++) begin
          if (sel_cmd.all) begin
            // sizes above the row length saturate by construction
            if (m < int'(sel_cmd.count)) map_nxt[d][m] = 1'b1;
          end else if (int'(sel_cmd.member) == m) begin
            map_nxt[d][m] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else if (sel_cmd.wr) begin
      map_r <= map_nxt;
    end
  end

  assign map_o = map_r;

endmodule

[design/sce_dim_scan.sv]
// Member scan of one dimension: lowest selected member, next one above a position,
// and whether more selected members follow. Depends on sce_pkg.
`timescale 1ns / 1ps

module sce_dim_scan #(
  parameter int MAX_MEMBERS = 128,
  parameter int PW          = 7
) (
  input  logic [MAX_MEMBERS-1:0] map_i,
  input  logic [PW-1:0]          pos_i,
  output logic [PW-1:0]          first_o,
  output logic [PW-1:0]          nxt_o,
  output sce_pkg::scan_flags_t   flags_o
);

  localparam logic [MAX_MEMBERS-1:0] ONE = 1;

  logic [MAX_MEMBERS-1:0] above;

  always_comb begin
    for (int m = 0; m < MAX_MEMBERS; m++) begin
      above[m] = map_i[m] && (m > int'(pos_i));
    end
  end

  // lowest set bit wins
  always_comb begin
    first_o = '0;
    nxt_o   = '0;
    for (int m = MAX_MEMBERS - 1; m >= 0; m--) begin
      if (map_i[m]) first_o = PW'(m);
      if (above[m]) nxt_o = PW'(m);
    end
  end

  assign flags_o.any       = |map_i;
  assign flags_o.multi     = |(map_i & (map_i - ONE));
  assign flags_o.nxt_any   = |above;
  assign flags_o.nxt_multi = |(above & (above - ONE));

endmodule

[design/selected_cell_enumerator_unit.sv]
// Top level of the selected cell enumerator: input register, odometer step, result register.
// Instantiates sce_sel_map and sce_dim_scan; depends on sce_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// in_       slave      in_tvalid / in_tready    tuser: command; tdata: dim, member
// out_      master     out_tvalid / out_tready  tuser: status; tlast: final_cell;
//                                               tdata: member_dim0..3, empty_dim
// cfg_      slave      cfg_valid / cfg_ready    cfg_index: register, cfg_data: value
//
// One beat per cycle sustained while out_tready stays high; a result passes through the
// input register, then the result register. The per-dimension member scans and the
// carry across dimensions settle within the single compute stage.
// Reset clears the bitmaps, positions and running flag at once: no clearing pass.
// A stalled result holds while the input register still takes one more beat.

module selected_cell_enumerator_unit #(
  parameter int MAX_DIMS    = 4,
  parameter int MAX_MEMBERS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sce_pkg::IN_TDATA_W-1:0]    in_tdata,   // [1:0] dim, [8:2] member, rest zero
  input  logic [sce_pkg::CMD_W-1:0]         in_tuser,   // [1:0] command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sce_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [6:0] member_dim0, [13:7] member_dim1,
                                                        // [20:14] member_dim2,
                                                        // [27:21] member_dim3,
                                                        // [29:28] empty_dim, rest zero
  output logic [sce_pkg::STATUS_W-1:0]      out_tuser,  // [1:0] status
  output logic                              out_tlast,  // final_cell
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sce_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW   = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int NDW  = $clog2(MAX_DIMS + 1);
  localparam int DIMW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int COORD_W = sce_pkg::OUT_DIMS * sce_pkg::MEMBER_W;
  localparam int PAD_W   = sce_pkg::OUT_TDATA_W - COORD_W - sce_pkg::DIM_W;

  // ---------------------------------------------------------------------------
  // Configuration registers: always ready, unknown indexes dropped.
  // ---------------------------------------------------------------------------
  logic [sce_pkg::DIMS_CFG_W-1:0]   dims_in_use_r;
  logic [3:0][sce_pkg::SIZE_W-1:0]  size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_in_use_r <= sce_pkg::DIMS_IN_USE_RST;
      size_r        <= {4{sce_pkg::SIZE_RST}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sce_pkg::REG_DIMS_IN_USE: dims_in_use_r <= cfg_data[sce_pkg::DIMS_CFG_W-1:0];
        sce_pkg::REG_SIZE_DIM0:   size_r[0] <= cfg_data;
        sce_pkg::REG_SIZE_DIM1:   size_r[1] <= cfg_data;
        sce_pkg::REG_SIZE_DIM2:   size_r[2] <= cfg_data;
        sce_pkg::REG_SIZE_DIM3:   size_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. Advance into compute whenever the result register frees up.
  // ---------------------------------------------------------------------------
  logic              in_valid_r;
  sce_pkg::in_item_t in_item_r;
  logic              adv;
  logic              out_valid_r;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.command <= in_tuser;
      in_item_r.dim     <= in_tdata[sce_pkg::DIM_W-1:0];
      in_item_r.member  <= in_tdata[sce_pkg::DIM_W +: sce_pkg::MEMBER_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Enumeration state and per-dimension scans.
  // ---------------------------------------------------------------------------
  logic                                  running_r;
  logic [MAX_DIMS-1:0][PW-1:0]           pos_r;
  logic [MAX_DIMS-1:0][MAX_MEMBERS-1:0]  map_w;
  logic [MAX_DIMS-1:0][PW-1:0]           first_w;
  logic [MAX_DIMS-1:0][PW-1:0]           nxt_w;
  sce_pkg::scan_flags_t [MAX_DIMS-1:0]   flags_w;
  sce_pkg::sel_cmd_t                     sel_cmd;

  sce_sel_map #(
    .MAX_DIMS    (MAX_DIMS),
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_sel_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .sel_cmd (sel_cmd),
    .map_o   (map_w)
  );

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_scan
    sce_dim_scan #(
      .MAX_MEMBERS (MAX_MEMBERS),
      .PW          (PW)
    ) u_scan (
      .map_i   (map_w[g]),
      .pos_i   (pos_r[g]),
      .first_o (first_w[g]),
      .nxt_o   (nxt_w[g]),
      .flags_o (flags_w[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Compute: command decode, empty-dimension search, odometer step.
  // ---------------------------------------------------------------------------
  logic [NDW-1:0]                                   nd;
  logic [MAX_DIMS-1:0]                              active;
  logic                                             has_emp;
  logic [DIMW-1:0]                                  emp;
  logic [MAX_DIMS-1:0][PW-1:0]                      pos_nxt;
  logic                                             running_nxt;
  logic [MAX_DIMS-1:0]                              more;
  logic                                             carry;
  logic                                             emit;
  logic                                             last;
  logic [sce_pkg::STATUS_W-1:0]                     status;
  logic [sce_pkg::OUT_DIMS-1:0][sce_pkg::MEMBER_W-1:0] coord;
  logic [sce_pkg::DIM_W-1:0]                        empty_dim;

  always_comb begin
    // clamp the dimension count into 1..MAX_DIMS
    if (dims_in_use_r == '0) begin
      nd = NDW'(1);
    end else if (int'(dims_in_use_r) > MAX_DIMS) begin
      nd = NDW'(MAX_DIMS);
    end else begin
      nd = NDW'(dims_in_use_r);
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      active[d] = d < int'(nd);
    end
    // first active dimension with nothing selected
    has_emp = 1'b0;
    emp     = '0;
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      if (active[d] && !flags_w[d].any) begin
        has_emp = 1'b1;
        emp     = DIMW'(d);
      end
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    running_nxt = running_r;
    status      = sce_pkg::ST_ACK;
    emit        = 1'b0;
    more        = '0;
    carry       = 1'b1;
    empty_dim   = '0;
    sel_cmd     = '0;
    unique case (in_item_r.command)
      sce_pkg::CMD_SEL_MEMBER, sce_pkg::CMD_SEL_ALL: begin
        // any select ends a running walk
        running_nxt    = 1'b0;
        sel_cmd.wr     = adv;
        sel_cmd.all    = (in_item_r.command == sce_pkg::CMD_SEL_ALL);
        sel_cmd.dim    = in_item_r.dim;
        sel_cmd.member = in_item_r.member;
        sel_cmd.count  = size_r[in_item_r.dim];
      end
      sce_pkg::CMD_START: begin
        // load first members up to the empty dimension, if there is one
        for (int d = 0; d < MAX_DIMS; d++) begin
          if (active[d] && (!has_emp || d < int'(emp))) pos_nxt[d] = first_w[d];
          more[d] = flags_w[d].multi;
        end
        if (has_emp) begin
          status      = sce_pkg::ST_EMPTY;
          running_nxt = 1'b0;
          empty_dim   = sce_pkg::DIM_W'(emp);
        end else begin
          status = sce_pkg::ST_CELL;
          emit   = 1'b1;
        end
      end
      sce_pkg::CMD_ADVANCE: begin
        if (!running_r) begin
          status = sce_pkg::ST_NOT_RUN;
        end else begin
          // dimension 0 turns fastest; wrap to the first member and carry up
          for (int d = 0; d < MAX_DIMS; d++) begin
            more[d] = flags_w[d].nxt_any;
            if (active[d] && carry) begin
              if (flags_w[d].nxt_any) begin
                pos_nxt[d] = nxt_w[d];
                more[d]    = flags_w[d].nxt_multi;
                carry      = 1'b0;
              end else begin
                pos_nxt[d] = first_w[d];
                more[d]    = flags_w[d].multi;
              end
            end
          end
          status = sce_pkg::ST_CELL;
          emit   = 1'b1;
        end
      end
      default: ;
    endcase

    last  = emit && !(|(more & active));
    if (emit) running_nxt = !last;

    coord = '0;
    for (int d = 0; d < sce_pkg::OUT_DIMS; d++) begin
      if (d < MAX_DIMS) begin
        if (emit && active[d]) coord[d] = sce_pkg::MEMBER_W'(pos_nxt[d]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      pos_r     <= '0;
    end else if (adv) begin
      running_r <= running_nxt;
      pos_r     <= pos_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold while the consumer stalls.
  // ---------------------------------------------------------------------------
  logic [sce_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [sce_pkg::STATUS_W-1:0]    out_tuser_r;
  logic                            out_tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {{PAD_W{1'b0}}, empty_dim, coord};
      out_tuser_r <= status;
      out_tlast_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_final_is_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == sce_pkg::ST_CELL)
    else $error("final flag on a beat that carries no cell");

  a_coords_only_cells: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != sce_pkg::ST_CELL |-> out_tdata[COORD_W-1:0] == '0)
    else $error("coordinates on a beat that carries no cell");

  a_select_stops: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_item_r.command == sce_pkg::CMD_SEL_MEMBER ||
            in_item_r.command == sce_pkg::CMD_SEL_ALL) |=> !running_r)
    else $error("walk still running after a select");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last |=> !running_r && out_tlast)
    else $error("walk still running after the final cell");

endmodule

[tb/sce_cell_checker.sv]
`timescale 1ns / 1ps
// Result checker for the selected cell enumerator: tracks the cfg, in and out channels.
// It predicts every result beat and compares it field by field with the block's output.
// Depends on sce_pkg for command and status codes, register indexes and widths.

module sce_cell_checker
  import sce_pkg::*;
#(
  parameter int MAX_DIMS    = 4,
  parameter int MAX_MEMBERS = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [STATUS_W-1:0]    out_tuser,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding,
  output int                     results_seen,
  output int                     cells_seen,
  output int                     finals_seen,
  output int                     empty_errors,
  output int                     not_running_seen
);

  localparam int NO_MEMBER = -1;

  typedef struct packed {
    logic [STATUS_W-1:0]               status;
    logic [OUT_DIMS-1:0][MEMBER_W-1:0] coord;
    logic                              last_combo;
    logic [DIM_W-1:0]                  empty_dim;
  } cell_result_t;

  logic [MAX_MEMBERS-1:0] picked [MAX_DIMS];
  int unsigned            odo_pos [MAX_DIMS];
  logic                   walking;
  logic [DIMS_CFG_W-1:0]  dims_reg;
  logic [SIZE_W-1:0]      size_reg [OUT_DIMS];
  cell_result_t           expected_cells [$];

  // lowest selected member of dimension d at or above from
  function automatic int next_pick(int d, int from);
    for (int m = from; m < MAX_MEMBERS; m++)
      if (picked[d][m]) return m;
    return NO_MEMBER;
  endfunction

  function automatic int live_dims();
    if (dims_reg == '0) return 1;
    if (int'(dims_reg) > MAX_DIMS) return MAX_DIMS;
    return int'(dims_reg);
  endfunction

  function automatic cell_result_t emit_cell(int nd);
    cell_result_t r;
    logic         last;
    r = '0;
    last = 1'b1;
    r.status = ST_CELL;
    for (int i = 0; i < nd; i++) begin
      if (i < OUT_DIMS) r.coord[i] = MEMBER_W'(odo_pos[i]);
      if (next_pick(i, odo_pos[i] + 1) != NO_MEMBER) last = 1'b0;
    end
    r.last_combo = last;
    walking = !last;
    return r;
  endfunction

  function automatic cell_result_t predict_cell(logic [CMD_W-1:0] cmd, logic [DIM_W-1:0] dim,
                                                logic [MEMBER_W-1:0] mem);
    cell_result_t r;
    int           nd;
    int           found;
    int unsigned  n;
    r = '0;
    nd = live_dims();
    case (cmd)
      CMD_SEL_MEMBER, CMD_SEL_ALL: begin
        walking = 1'b0;
        if (int'(dim) < MAX_DIMS) begin
          if (cmd == CMD_SEL_MEMBER) begin
            if (int'(mem) < MAX_MEMBERS) picked[dim][mem] = 1'b1;
          end else begin
            n = 32'(size_reg[dim]);
            if (n > MAX_MEMBERS) n = MAX_MEMBERS;
            for (int m = 0; m < n; m++) picked[dim][m] = 1'b1;
          end
        end
        r.status = ST_ACK;
      end
      CMD_START: begin
        for (int i = 0; i < nd; i++) begin
          found = next_pick(i, 0);
          if (found == NO_MEMBER) begin
            walking = 1'b0;
            r.status = ST_EMPTY;
            r.empty_dim = DIM_W'(i);
            return r;
          end
          odo_pos[i] = found;
        end
        r = emit_cell(nd);
      end
      default: begin
        if (!walking) begin
          r.status = ST_NOT_RUN;
        end else begin
          // odometer step: dimension 0 moves first, wrap and carry upward
          for (int i = 0; i < nd; i++) begin
            found = next_pick(i, odo_pos[i] + 1);
            if (found != NO_MEMBER) begin
              odo_pos[i] = found;
              break;
            end
            found = next_pick(i, 0);
            odo_pos[i] = (found == NO_MEMBER) ? 0 : found;
          end
          r = emit_cell(nd);
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    cell_result_t want;
    if (!rst_n) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        picked[d] = '0;
        odo_pos[d] = 0;
      end
      for (int d = 0; d < OUT_DIMS; d++) size_reg[d] = SIZE_RST;
      walking = 1'b0;
      dims_reg = DIMS_IN_USE_RST;
      expected_cells.delete();
      mismatches = 0;
      results_seen = 0;
      cells_seen = 0;
      finals_seen = 0;
      empty_errors = 0;
      not_running_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIMS_IN_USE: dims_reg = cfg_data[DIMS_CFG_W-1:0];
          REG_SIZE_DIM0:   size_reg[0] = cfg_data;
          REG_SIZE_DIM1:   size_reg[1] = cfg_data;
          REG_SIZE_DIM2:   size_reg[2] = cfg_data;
          REG_SIZE_DIM3:   size_reg[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_cells.push_back(predict_cell(in_tuser, in_tdata[1:0], in_tdata[8:2]));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_cells.size() == 0) begin
          $error("result beat with no expectation pending: status %0d", out_tuser);
          mismatches++;
        end else begin
          want = expected_cells.pop_front();
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("member_dim0", 32'(want.coord[0]), 32'(out_tdata[6:0]));
          check_field("member_dim1", 32'(want.coord[1]), 32'(out_tdata[13:7]));
          check_field("member_dim2", 32'(want.coord[2]), 32'(out_tdata[20:14]));
          check_field("member_dim3", 32'(want.coord[3]), 32'(out_tdata[27:21]));
          check_field("final_cell", 32'(want.last_combo), 32'(out_tlast));
          check_field("empty_dim", 32'(want.empty_dim), 32'(out_tdata[29:28]));
          case (want.status)
            ST_CELL: begin
              cells_seen++;
              if (want.last_combo) finals_seen++;
            end
            ST_EMPTY:   empty_errors++;
            ST_NOT_RUN: not_running_seen++;
            default: ;
          endcase
        end
      end
    end
    outstanding = expected_cells.size();
  end

endmodule

[tb/tb_selected_cell_enumerator_unit.sv]
`timescale 1ns / 1ps
// Testbench top for selected_cell_enumerator_unit: clock, reset, stimulus and verdict.
// Instantiates the block and sce_cell_checker; depends on sce_pkg.

module tb_selected_cell_enumerator_unit;
  import sce_pkg::*;

  localparam int HOLD_OFF_CYCLES = 60;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [1:0] dim, [8:2] member, rest zero
  logic [CMD_W-1:0]       in_tuser;   // [1:0] command
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [6:0] member_dim0 .. [27:21] member_dim3, [29:28] empty_dim
  logic [STATUS_W-1:0]    out_tuser;  // [1:0] status
  logic                   out_tlast;  // final_cell
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches, outstanding, results_seen, cells_seen, finals_seen;
  int empty_errors, not_running_seen;

  // idle_on enables random gaps on both sides; long_hold_req asks the receiver
  // for one long hold-off so the block backs up into its input
  bit idle_on;
  bit long_hold_req;

  selected_cell_enumerator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sce_cell_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_seen     (results_seen),
    .cells_seen       (cells_seen),
    .finals_seen      (finals_seen),
    .empty_errors     (empty_errors),
    .not_running_seen (not_running_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: drive out_tready at the falling edge. One nonblocking assignment per
  // step: each pass of the loop starts on a fresh falling edge.
  initial begin : result_sink
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        // hold off long enough for the block to fill and drop in_tready
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one command beat and wait for its handshake. Keep in_tvalid high from
  // one beat to the next unless an idle burst comes in between.
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [DIM_W-1:0] dim,
                           logic [MEMBER_W-1:0] mem);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_TDATA_W'({mem, dim});
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop the input and wait until every expected result has come back, then let
  // the two-stage pipe drain before touching the registers.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write all five registers back to back, then release the channel.
  task automatic write_regs(logic [DIMS_CFG_W-1:0] dims, logic [SIZE_W-1:0] s0,
                            logic [SIZE_W-1:0] s1, logic [SIZE_W-1:0] s2,
                            logic [SIZE_W-1:0] s3);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{REG_DIMS_IN_USE, REG_SIZE_DIM0, REG_SIZE_DIM1, REG_SIZE_DIM2, REG_SIZE_DIM3};
    val = '{CFG_DATA_W'(dims), s0, s1, s2, s3};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Keep dimensions 0..2 to a small member pool so that walks still finish;
  // dimension 3 takes any member since it mostly sits outside the walk.
  function automatic logic [MEMBER_W-1:0] pick_member(int d);
    int r;
    if (d == 3) return MEMBER_W'($urandom_range(0, 127));
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return MEMBER_W'($urandom_range(1, 9));
  endfunction

  // Mostly well-formed walks: a few selects, a start, a run of advances that often
  // overshoots the final cell. The rest is single random commands.
  task automatic run_walks(int n, int hot);
    int sent, nsel, k, d;
    logic [CMD_W-1:0] c;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        nsel = $urandom_range(0, 2);
        repeat (nsel) begin
          d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, hot - 1);
          if ($urandom_range(0, 3) == 0)
            send_beat(CMD_SEL_ALL, DIM_W'(d), MEMBER_W'($urandom_range(0, 127)));
          else
            send_beat(CMD_SEL_MEMBER, DIM_W'(d), pick_member(d));
          sent++;
        end
        send_beat(CMD_START, DIM_W'($urandom_range(0, 3)), MEMBER_W'($urandom_range(0, 127)));
        sent++;
        k = $urandom_range(0, 24);
        repeat (k) begin
          send_beat(CMD_ADVANCE, DIM_W'($urandom_range(0, 3)),
                    MEMBER_W'($urandom_range(0, 127)));
          sent++;
        end
      end else begin
        c = CMD_W'($urandom_range(0, 3));
        d = $urandom_range(0, 3);
        send_beat(c, DIM_W'(d),
                  (c == CMD_SEL_MEMBER) ? pick_member(d) : MEMBER_W'($urandom_range(0, 127)));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    long_hold_req = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: four dims, small sizes; size 0 on dim 1 makes select all a no-op.
    write_regs(3'd4, 8'd2, 8'd0, 8'd1, 8'd3);
    send_beat(CMD_ADVANCE,    2'd0, 7'd0);    // advance before any start: not running
    send_beat(CMD_START,      2'd3, 7'd127);  // nothing selected anywhere: empty dim 0
    send_beat(CMD_SEL_ALL,    2'd1, 7'd0);    // size 0 selects nothing
    send_beat(CMD_SEL_ALL,    2'd0, 7'd85);   // dim 0 gets members 0 and 1
    send_beat(CMD_START,      2'd0, 7'd0);    // empty dim 1
    send_beat(CMD_SEL_MEMBER, 2'd1, 7'd127);  // top member
    send_beat(CMD_SEL_MEMBER, 2'd2, 7'd0);
    send_beat(CMD_START,      2'd1, 7'd42);   // empty dim 3
    send_beat(CMD_SEL_MEMBER, 2'd3, 7'd100);
    send_beat(CMD_START,      2'd2, 7'd0);    // first cell
    send_beat(CMD_ADVANCE,    2'd1, 7'd127);  // last cell
    send_beat(CMD_ADVANCE,    2'd2, 7'd0);    // past the last cell: not running
    send_beat(CMD_SEL_ALL,    2'd2, 7'd127);  // size 1: member 0 again
    send_beat(CMD_SEL_MEMBER, 2'd1, 7'd0);
    send_beat(CMD_START,      2'd3, 7'd1);
    send_beat(CMD_ADVANCE,    2'd0, 7'd64);
    send_beat(CMD_SEL_MEMBER, 2'd0, 7'd1);    // select while running ends the walk
    send_beat(CMD_ADVANCE,    2'd3, 7'd0);    // not running
    send_beat(CMD_START,      2'd0, 7'd0);
    send_beat(CMD_ADVANCE,    2'd0, 7'd0);
    send_beat(CMD_ADVANCE,    2'd0, 7'd0);    // dim 0 wraps, carry into dim 1
    send_beat(CMD_ADVANCE,    2'd0, 7'd0);    // final combination
    send_beat(CMD_ADVANCE,    2'd0, 7'd0);    // not running
    drain();

    // dims_in_use 0 clamps to one; size above the member count saturates on dim 3
    write_regs(3'd0, 8'd3, 8'd1, 8'd2, 8'd255);
    send_beat(CMD_SEL_ALL, 2'd3, 7'd0);
    run_walks(80, 1);
    drain();

    // two dims; force one long receiver hold-off while the sender keeps going
    write_regs(3'd2, 8'd1, 8'd4, 8'd0, 8'd128);
    long_hold_req = 1'b1;
    run_walks(80, 2);
    drain();

    write_regs(3'd3, 8'd2, 8'd2, 8'd2, 8'd128);
    run_walks(80, 3);
    drain();

    // dims_in_use 7 clamps to four
    write_regs(3'd7, 8'd1, 8'd1, 8'd1, 8'd200);
    run_walks(80, 4);
    drain();

    // closing stretch: no idling on either side
    idle_on = 1'b0;
    write_regs(3'd1, 8'd4, 8'd3, 8'd2, 8'd1);
    run_walks(80, 1);
    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d result beats: %0d cells (%0d final), %0d empty-dimension errors,",
             results_seen, cells_seen, finals_seen, empty_errors);
    $display("%0d not-running replies, over dimension counts 0 to 7 and sizes 0 to 255.",
             not_running_seen);
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
